>>> hw/rtl/stfcd_pkg.sv
// Shared constants, codes and interface types of the seek table frame cache directory.
package stfcd_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CACHE_WAYS = 4;
    localparam int WAY_W      = 2;
    localparam int MISS_LIMIT = 8;
    localparam int MS_W       = 4;
    localparam int OFF_W      = 48;
    localparam int SZ_W       = 32;
    localparam int ST_W       = 3;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_SEEK   = 2'd2;
    localparam logic [1:0] MODE_BOUND  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_HIT     = 3'd1;
    localparam logic [ST_W-1:0] ST_MISS    = 3'd2;
    localparam logic [ST_W-1:0] ST_CACHEDN = 3'd3;
    localparam logic [ST_W-1:0] ST_NOMATCH = 3'd4;
    localparam logic [ST_W-1:0] ST_INVALID = 3'd5;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd6;

    localparam logic CFG_EXPECTED = 1'b0;
    localparam logic CFG_KNOWN    = 1'b1;

    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_CAP        = 4'd1;
    localparam logic [3:0] OP_DISPATCH   = 4'd2;
    localparam logic [3:0] OP_TOP        = 4'd3;
    localparam logic [3:0] OP_BS_ISSUE   = 4'd4;
    localparam logic [3:0] OP_BS_CMP     = 4'd5;
    localparam logic [3:0] OP_SET_F_LO   = 4'd6;
    localparam logic [3:0] OP_DESC0      = 4'd7;
    localparam logic [3:0] OP_DESC1      = 4'd8;
    localparam logic [3:0] OP_DESC2      = 4'd9;
    localparam logic [3:0] OP_SEEK_CACHE = 4'd10;
    localparam logic [3:0] OP_BND_RD     = 4'd11;
    localparam logic [3:0] OP_BND_CMP    = 4'd12;
    localparam logic [3:0] OP_OUT        = 4'd13;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       table_ok;
        logic       cache_on;
        logic       top_ge;
        logic       bs_more;
        logic       bnd_match;
        logic       bnd_last;
        logic       out_free;
    } sts_t;

endpackage

>>> hw/rtl/stfcd_datapath.sv
// Datapath: offset tables, search registers, tag set with LRU ages and result registers.
module stfcd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stfcd_pkg::cmd_t               cmd,
    output stfcd_pkg::sts_t               sts,
    input  logic [1:0]                    mode,
    input  logic [stfcd_pkg::SZ_W-1:0]    comp_bytes,
    input  logic [stfcd_pkg::SZ_W-1:0]    decomp_bytes,
    input  logic [stfcd_pkg::OFF_W-1:0]   seek_pos,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [stfcd_pkg::OFF_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stfcd_pkg::ST_W-1:0]    status,
    output logic [stfcd_pkg::IDX_W-1:0]   frame_index,
    output logic [stfcd_pkg::WAY_W-1:0]   cache_slot,
    output logic [stfcd_pkg::OFF_W-1:0]   frame_comp_offset,
    output logic [stfcd_pkg::OFF_W-1:0]   frame_decomp_offset,
    output logic [stfcd_pkg::SZ_W-1:0]    frame_length,
    output logic [stfcd_pkg::SZ_W-1:0]    local_offset,
    output logic [stfcd_pkg::OFF_W-1:0]   next_comp_offset,
    output logic                          next_exists,
    output logic                          cache_enabled
);
    import stfcd_pkg::*;

    logic [OFF_W-1:0] comp_mem   [MAX_FRAMES];
    logic [OFF_W-1:0] decomp_mem [MAX_FRAMES];
    logic [OFF_W-1:0] rd_c, rd_d;
    logic [IDX_W-1:0] raddr;
    logic             wr_en;
    logic [IDX_W-1:0] waddr;

    logic [OFF_W-1:0] expected_reg, expected_next;
    logic             known_reg, known_next;
    logic [1:0]       mode_reg, mode_next;
    logic [SZ_W-1:0]  csz_reg, csz_next, dsz_reg, dsz_next;
    logic [OFF_W-1:0] tgt_reg, tgt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [OFF_W-1:0] csum_reg, csum_next, dsum_reg, dsum_next, total_reg, total_next;
    logic             table_ok_reg, table_ok_next, sealed_reg, sealed_next;
    logic             cache_on_reg, cache_on_next;
    logic [IDX_W-1:0] tag_reg [CACHE_WAYS];
    logic [IDX_W-1:0] tag_next [CACHE_WAYS];
    logic             valid_reg [CACHE_WAYS];
    logic             valid_next [CACHE_WAYS];
    logic [WAY_W-1:0] age_reg [CACHE_WAYS];
    logic [WAY_W-1:0] age_next [CACHE_WAYS];
    logic [MS_W-1:0]  ms_reg, ms_next;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next, f_reg, f_next;
    logic [WAY_W-1:0] way_reg, way_next;
    logic [OFF_W-1:0] sd_reg, sd_next;

    logic [ST_W-1:0]  rst_reg, rst_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [WAY_W-1:0] rslot_reg, rslot_next;
    logic [OFF_W-1:0] rco_reg, rco_next, rdo_reg, rdo_next, rnc_reg, rnc_next;
    logic [SZ_W-1:0]  rlen_reg, rlen_next, rloc_reg, rloc_next;
    logic             rne_reg, rne_next;

    logic             ov_reg, ov_next;
    logic [ST_W-1:0]  o_st_reg;
    logic [IDX_W-1:0] o_idx_reg;
    logic [WAY_W-1:0] o_slot_reg;
    logic [OFF_W-1:0] o_co_reg, o_do_reg, o_nc_reg;
    logic [SZ_W-1:0]  o_len_reg, o_loc_reg;
    logic             o_ne_reg, o_ce_reg;

    logic [CNT_W-1:0] cnt_eff;
    logic [OFF_W-1:0] csum_eff, dsum_eff;
    logic [IDX_W-1:0] last_idx, mid;
    logic [CNT_W-1:0] f_plus;
    logic             has_next;
    logic             hit_any;
    logic [WAY_W-1:0] hit_way, victim;
    logic [MS_W-1:0]  ms_inc;
    logic [OFF_W-1:0] next_d;

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign f_plus   = {1'b0, f_reg} + CNT_W'(1);
    assign has_next = f_plus < count_reg;
    assign ms_inc   = ms_reg + MS_W'(1);
    assign next_d   = has_next ? rd_d : total_reg;

    always_comb
    begin
        hit_any   = 1'b0;
        hit_way   = '0;
        victim    = '0;
        for (int w = CACHE_WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[w] && tag_reg[w] == f_reg)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = CACHE_WAYS - 1; w >= 0; w--)
        begin
            if (age_reg[w] == WAY_W'(CACHE_WAYS - 1))
            begin
                victim = WAY_W'(w);
            end
        end
        // first empty way takes precedence over the LRU way
        for (int w = CACHE_WAYS - 1; w >= 0; w--)
        begin
            if (!valid_reg[w])
            begin
                victim    = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        cnt_eff  = sealed_reg ? '0 : count_reg;
        csum_eff = sealed_reg ? '0 : csum_reg;
        dsum_eff = sealed_reg ? '0 : dsum_reg;
        case (cmd.op)
            OP_BS_ISSUE: raddr = mid;
            OP_DESC0:    raddr = f_reg;
            OP_DESC1:    raddr = IDX_W'(f_plus);
            OP_BND_RD:   raddr = tag_reg[way_reg];
            default:     raddr = last_idx;
        endcase
    end

    assign sts.mode      = mode_reg;
    assign sts.table_ok  = table_ok_reg;
    assign sts.cache_on  = cache_on_reg;
    assign sts.top_ge    = tgt_reg >= rd_d;
    assign sts.bs_more   = ({1'b0, lo_reg} + CNT_W'(1)) < {1'b0, hi_reg};
    assign sts.bnd_match = valid_reg[way_reg] && ({1'b0, tag_reg[way_reg]} < count_reg)
                           && rd_d == tgt_reg;
    assign sts.bnd_last  = way_reg == WAY_W'(CACHE_WAYS - 1);
    assign sts.out_free  = !ov_reg || out_ready;

    always_comb
    begin
        logic [WAY_W-1:0] tw;
        logic             touch, clr;
        tw    = '0;
        touch = 1'b0;
        clr   = 1'b0;

        expected_next = expected_reg;
        known_next    = known_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_EXPECTED)
                expected_next = cfg_data;
            else
                known_next = cfg_data[0];
        end

        mode_next     = mode_reg;
        csz_next      = csz_reg;
        dsz_next      = dsz_reg;
        tgt_next      = tgt_reg;
        count_next    = count_reg;
        csum_next     = csum_reg;
        dsum_next     = dsum_reg;
        total_next    = total_reg;
        table_ok_next = table_ok_reg;
        sealed_next   = sealed_reg;
        cache_on_next = cache_on_reg;
        ms_next       = ms_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        f_next        = f_reg;
        way_next      = way_reg;
        sd_next       = sd_reg;
        rst_next      = rst_reg;
        ridx_next     = ridx_reg;
        rslot_next    = rslot_reg;
        rco_next      = rco_reg;
        rdo_next      = rdo_reg;
        rnc_next      = rnc_reg;
        rlen_next     = rlen_reg;
        rloc_next     = rloc_reg;
        rne_next      = rne_reg;
        wr_en         = 1'b0;
        waddr         = IDX_W'(cnt_eff);
        for (int w = 0; w < CACHE_WAYS; w++)
        begin
            tag_next[w]   = tag_reg[w];
            valid_next[w] = valid_reg[w];
            age_next[w]   = age_reg[w];
        end
        ov_next = ov_reg && !out_ready;

        case (cmd.op)
            OP_CAP:
            begin
                mode_next  = mode;
                csz_next   = comp_bytes;
                dsz_next   = decomp_bytes;
                tgt_next   = seek_pos;
                rst_next   = ST_OK;
                ridx_next  = '0;
                rslot_next = '0;
                rco_next   = '0;
                rdo_next   = '0;
                rnc_next   = '0;
                rlen_next  = '0;
                rloc_next  = '0;
                rne_next   = 1'b0;
                way_next   = '0;
            end
            OP_DISPATCH:
            begin
                case (mode_reg)
                    MODE_LOAD:
                    begin
                        if (sealed_reg)
                        begin
                            sealed_next   = 1'b0;
                            table_ok_next = 1'b0;
                            cache_on_next = 1'b0;
                        end
                        count_next = cnt_eff;
                        csum_next  = csum_eff;
                        dsum_next  = dsum_eff;
                        if (cnt_eff >= CNT_W'(MAX_FRAMES))
                            rst_next = ST_FULL;
                        else
                        begin
                            wr_en      = 1'b1;
                            ridx_next  = IDX_W'(cnt_eff);
                            rco_next   = csum_eff;
                            rdo_next   = dsum_eff;
                            rlen_next  = dsz_reg;
                            csum_next  = csum_eff + OFF_W'(csz_reg);
                            dsum_next  = dsum_eff + OFF_W'(dsz_reg);
                            count_next = cnt_eff + CNT_W'(1);
                        end
                    end
                    MODE_FINISH:
                    begin
                        sealed_next = 1'b1;
                        if (count_reg < CNT_W'(2) || (known_reg && dsum_reg != expected_reg))
                        begin
                            rst_next      = ST_INVALID;
                            table_ok_next = 1'b0;
                            cache_on_next = 1'b0;
                        end
                        else
                        begin
                            total_next    = dsum_reg;
                            table_ok_next = 1'b1;
                            cache_on_next = 1'b1;
                            ms_next       = '0;
                            clr           = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!table_ok_reg)
                            rst_next = ST_INVALID;
                        else if (mode_reg == MODE_BOUND && !cache_on_reg)
                            rst_next = ST_NOMATCH;
                    end
                endcase
            end
            OP_TOP:
            begin
                if (tgt_reg >= rd_d)
                    f_next = last_idx;
                else
                begin
                    lo_next = '0;
                    hi_next = last_idx;
                end
            end
            OP_BS_CMP:
            begin
                if (rd_d <= tgt_reg)
                    lo_next = mid;
                else
                    hi_next = mid;
            end
            OP_SET_F_LO: f_next = lo_reg;
            OP_DESC1:
            begin
                sd_next   = rd_d;
                ridx_next = f_reg;
                rco_next  = rd_c;
                rdo_next  = rd_d;
            end
            OP_DESC2:
            begin
                rne_next  = has_next;
                rnc_next  = has_next ? rd_c : '0;
                rlen_next = next_d[SZ_W-1:0] - sd_reg[SZ_W-1:0];
                rloc_next = tgt_reg[SZ_W-1:0] - sd_reg[SZ_W-1:0];
                if (mode_reg == MODE_BOUND)
                begin
                    rst_next   = ST_HIT;
                    rslot_next = way_reg;
                    touch      = 1'b1;
                    tw         = way_reg;
                end
            end
            OP_SEEK_CACHE:
            begin
                if (!cache_on_reg)
                    rst_next = ST_NOMATCH;
                else if (hit_any)
                begin
                    touch      = 1'b1;
                    tw         = hit_way;
                    ms_next    = '0;
                    rst_next   = ST_HIT;
                    rslot_next = hit_way;
                end
                else if (ms_inc >= MS_W'(MISS_LIMIT))
                begin
                    cache_on_next = 1'b0;
                    clr           = 1'b1;
                    ms_next       = '0;
                    rst_next      = ST_CACHEDN;
                end
                else
                begin
                    tag_next[victim]   = f_reg;
                    valid_next[victim] = 1'b1;
                    touch              = 1'b1;
                    tw                 = victim;
                    ms_next            = ms_inc;
                    rst_next           = ST_MISS;
                    rslot_next         = victim;
                end
            end
            OP_BND_CMP:
            begin
                if (sts.bnd_match)
                    f_next = tag_reg[way_reg];
                else if (sts.bnd_last)
                    rst_next = ST_NOMATCH;
                else
                    way_next = way_reg + WAY_W'(1);
            end
            OP_OUT: ov_next = 1'b1;
            default:
            begin
            end
        endcase

        // move-to-front on the age ranks; ranks stay a permutation of the ways
        if (touch)
        begin
            for (int w = 0; w < CACHE_WAYS; w++)
            begin
                if (WAY_W'(w) == tw)
                    age_next[w] = '0;
                else if (age_reg[w] < age_reg[tw])
                    age_next[w] = age_reg[w] + WAY_W'(1);
            end
        end
        if (clr)
        begin
            for (int w = 0; w < CACHE_WAYS; w++)
            begin
                tag_next[w]   = '0;
                valid_next[w] = 1'b0;
                age_next[w]   = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            comp_mem[waddr]   <= csum_eff;
            decomp_mem[waddr] <= dsum_eff;
        end
        rd_c <= comp_mem[raddr];
        rd_d <= decomp_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            known_reg    <= 1'b0;
            count_reg    <= '0;
            csum_reg     <= '0;
            dsum_reg     <= '0;
            total_reg    <= '0;
            table_ok_reg <= 1'b0;
            sealed_reg   <= 1'b0;
            cache_on_reg <= 1'b0;
            ms_reg       <= '0;
            ov_reg       <= 1'b0;
            for (int w = 0; w < CACHE_WAYS; w++)
            begin
                tag_reg[w]   <= '0;
                valid_reg[w] <= 1'b0;
                age_reg[w]   <= WAY_W'(w);
            end
        end
        else
        begin
            expected_reg <= expected_next;
            known_reg    <= known_next;
            count_reg    <= count_next;
            csum_reg     <= csum_next;
            dsum_reg     <= dsum_next;
            total_reg    <= total_next;
            table_ok_reg <= table_ok_next;
            sealed_reg   <= sealed_next;
            cache_on_reg <= cache_on_next;
            ms_reg       <= ms_next;
            ov_reg       <= ov_next;
            for (int w = 0; w < CACHE_WAYS; w++)
            begin
                tag_reg[w]   <= tag_next[w];
                valid_reg[w] <= valid_next[w];
                age_reg[w]   <= age_next[w];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        csz_reg   <= csz_next;
        dsz_reg   <= dsz_next;
        tgt_reg   <= tgt_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        f_reg     <= f_next;
        way_reg   <= way_next;
        sd_reg    <= sd_next;
        rst_reg   <= rst_next;
        ridx_reg  <= ridx_next;
        rslot_reg <= rslot_next;
        rco_reg   <= rco_next;
        rdo_reg   <= rdo_next;
        rnc_reg   <= rnc_next;
        rlen_reg  <= rlen_next;
        rloc_reg  <= rloc_next;
        rne_reg   <= rne_next;
        if (cmd.op == OP_OUT)
        begin
            o_st_reg   <= rst_reg;
            o_idx_reg  <= ridx_reg;
            o_slot_reg <= rslot_reg;
            o_co_reg   <= rco_reg;
            o_do_reg   <= rdo_reg;
            o_nc_reg   <= rnc_reg;
            o_len_reg  <= rlen_reg;
            o_loc_reg  <= rloc_reg;
            o_ne_reg   <= rne_reg;
            o_ce_reg   <= cache_on_reg;
        end
    end

    assign out_valid           = ov_reg;
    assign status              = o_st_reg;
    assign frame_index         = o_idx_reg;
    assign cache_slot          = o_slot_reg;
    assign frame_comp_offset   = o_co_reg;
    assign frame_decomp_offset = o_do_reg;
    assign frame_length        = o_len_reg;
    assign local_offset        = o_loc_reg;
    assign next_comp_offset    = o_nc_reg;
    assign next_exists         = o_ne_reg;
    assign cache_enabled       = o_ce_reg;

endmodule

>>> hw/rtl/stfcd_controller.sv
// Controller: sequences load, finish, binary search, tag lookup and boundary scan.
module stfcd_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  stfcd_pkg::sts_t sts,
    output stfcd_pkg::cmd_t cmd
);
    import stfcd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_TOP  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_D0   = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_D2   = 4'd7;
    localparam logic [3:0] S_LOOK = 4'd8;
    localparam logic [3:0] S_BRD  = 4'd9;
    localparam logic [3:0] S_BCMP = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0] state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAP;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.op = OP_DISPATCH;
                if (sts.mode == MODE_LOAD || sts.mode == MODE_FINISH || !sts.table_ok)
                    state_next = S_DONE;
                else if (sts.mode == MODE_SEEK)
                    state_next = S_TOP;
                else if (!sts.cache_on)
                    state_next = S_DONE;
                else
                    state_next = S_BRD;
            end
            S_TOP:
            begin
                cmd.op     = OP_TOP;
                state_next = sts.top_ge ? S_D0 : S_CHK;
            end
            S_CHK:
            begin
                if (sts.bs_more)
                begin
                    cmd.op     = OP_BS_ISSUE;
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.op     = OP_SET_F_LO;
                    state_next = S_D0;
                end
            end
            S_CMP:
            begin
                cmd.op     = OP_BS_CMP;
                state_next = S_CHK;
            end
            S_D0:
            begin
                cmd.op     = OP_DESC0;
                state_next = S_D1;
            end
            S_D1:
            begin
                cmd.op     = OP_DESC1;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.op     = OP_DESC2;
                state_next = (sts.mode == MODE_SEEK) ? S_LOOK : S_DONE;
            end
            S_LOOK:
            begin
                cmd.op     = OP_SEEK_CACHE;
                state_next = S_DONE;
            end
            S_BRD:
            begin
                cmd.op     = OP_BND_RD;
                state_next = S_BCMP;
            end
            S_BCMP:
            begin
                cmd.op = OP_BND_CMP;
                if (sts.bnd_match)
                    state_next = S_D0;
                else if (sts.bnd_last)
                    state_next = S_DONE;
                else
                    state_next = S_BRD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hw/rtl/seek_table_frame_cache_directory_core.sv
// Top level of the seek table frame cache directory: controller plus datapath.
// One request is in work at a time. A load or finish request, and any request
// without a valid table, goes straight from dispatch to the output. A seek
// describes the last frame directly when the target is at or past its start;
// otherwise a binary search finds the frame first, each probe issuing a read on
// the single registered read port of the offset tables and then comparing. A
// boundary request with the cache on reads and compares one tag at a time until
// a match or the last way, and describes a matching frame. A new request is
// taken while a finished result waits at the output register.
module seek_table_frame_cache_directory_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [stfcd_pkg::SZ_W-1:0]    comp_bytes,
    input  logic [stfcd_pkg::SZ_W-1:0]    decomp_bytes,
    input  logic [stfcd_pkg::OFF_W-1:0]   seek_pos,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stfcd_pkg::ST_W-1:0]    status,
    output logic [stfcd_pkg::IDX_W-1:0]   frame_index,
    output logic [stfcd_pkg::WAY_W-1:0]   cache_slot,
    output logic [stfcd_pkg::OFF_W-1:0]   frame_comp_offset,
    output logic [stfcd_pkg::OFF_W-1:0]   frame_decomp_offset,
    output logic [stfcd_pkg::SZ_W-1:0]    frame_length,
    output logic [stfcd_pkg::SZ_W-1:0]    local_offset,
    output logic [stfcd_pkg::OFF_W-1:0]   next_comp_offset,
    output logic                          next_exists,
    output logic                          cache_enabled,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [stfcd_pkg::OFF_W-1:0]   cfg_data
);
    import stfcd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    stfcd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stfcd_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .mode                (mode),
        .comp_bytes          (comp_bytes),
        .decomp_bytes        (decomp_bytes),
        .seek_pos            (seek_pos),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .status              (status),
        .frame_index         (frame_index),
        .cache_slot          (cache_slot),
        .frame_comp_offset   (frame_comp_offset),
        .frame_decomp_offset (frame_decomp_offset),
        .frame_length        (frame_length),
        .local_offset        (local_offset),
        .next_comp_offset    (next_comp_offset),
        .next_exists         (next_exists),
        .cache_enabled       (cache_enabled)
    );

endmodule
